FILE: rtl/hsort_pkg.sv
// Shared types and constants for the heap sorter of directory entries.
package hsort_pkg;

    localparam int unsigned KEY_W = 63;
    localparam int unsigned TAG_W = 16;
    localparam int unsigned SEL_W = 2;

    // Key select codes
    localparam logic [SEL_W-1:0] SEL_DATA = 2'd0;
    localparam logic [SEL_W-1:0] SEL_REAL = 2'd1;
    localparam logic [SEL_W-1:0] SEL_DISK = 2'd2;

    // One stored heap entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DECIDE,
        ST_EX_RD,
        ST_EX_MOVE,
        ST_SD_RD,
        ST_SD_CMP,
        ST_EX_NEXT,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMPTY
    } state_t;

endpackage

FILE: rtl/heap_sort_entries_by_size.sv
// Heap sorter of directory entries by a selectable size, largest first.

// Entries arrive one item at a time; an entry with a nonzero data size is keyed on the
// size picked by sort_select at arrival and inserted into a binary min-heap held in a
// two-read, one-write memory of HEAP_DEPTH entries. 63-bit comparators, driven by a
// small sequencer, do all heap work, and every memory read is registered. An insertion
// keeps in_ready low while the entry climbs the heap through ST_UP_RD and ST_UP_CMP,
// and a dropped entry keeps it low through ST_INS and ST_DECIDE. On the item marked
// last_in, the store is heapsorted in place: each extraction step fetches the tail entry
// and the root, parks the root at the tail and walks the moved entry down. After that,
// the entries are sent largest first, one at a time, each waiting until the output
// register frees up. The store then empties. A load with no stored entry yields one
// marker result with valid_entry low. Entries that arrive once the store is full are
// dropped and raise overflowed on every result of that run. A finished result waits in
// the output register while new items are taken.
module heap_sort_entries_by_size #(
    parameter int unsigned HEAP_DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_wr_en,
    input  logic [hsort_pkg::SEL_W-1:0] cfg_wr_data,
    // input channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [hsort_pkg::TAG_W-1:0] entry_tag,
    input  logic [hsort_pkg::KEY_W-1:0] data_size,
    input  logic [hsort_pkg::KEY_W-1:0] real_size,
    input  logic [hsort_pkg::KEY_W-1:0] disk_size,
    input  logic                       last_in,
    // output channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [hsort_pkg::TAG_W-1:0] out_tag,
    output logic [hsort_pkg::KEY_W-1:0] out_key,
    output logic                       valid_entry,
    output logic                       overflowed,
    output logic                       last_out
);

    localparam int unsigned AW = $clog2(HEAP_DEPTH);
    localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    hsort_pkg::state_t state_reg, state_next;

    logic [hsort_pkg::SEL_W-1:0] sort_select_reg;
    logic [CW-1:0]               count_reg, count_next;
    logic                        ovf_reg, ovf_next;

    hsort_pkg::entry_t           new_reg, new_next;
    logic                        kept_reg, kept_next;
    logic                        last_reg, last_next;

    logic [AW-1:0]               hole_reg, hole_next;
    logic [AW-1:0]               ext_last_reg, ext_last_next;
    logic [AW-1:0]               idx_reg, idx_next;
    hsort_pkg::entry_t           mov_reg, mov_next;

    logic                        out_valid_reg, out_valid_next;
    hsort_pkg::entry_t           out_ent_reg, out_ent_next;
    logic                        valid_entry_reg, valid_entry_next;
    logic                        ovf_out_reg, ovf_out_next;
    logic                        last_out_reg, last_out_next;

    // Heap memory: two registered read ports, one write port
    hsort_pkg::entry_t           heap_mem [HEAP_DEPTH];
    logic [AW-1:0]               rd_addr_a, rd_addr_b;
    hsort_pkg::entry_t           rd_a_reg, rd_b_reg;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    hsort_pkg::entry_t           wr_data;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic [AW-1:0]               parent_idx;
    logic [AW:0]                 child_a;
    logic [AW:0]                 child_b;
    logic                        use_b;
    hsort_pkg::entry_t           pick_ent;
    logic [AW-1:0]               pick_idx;
    logic                        out_free;
    logic [hsort_pkg::KEY_W-1:0] sel_key;
    logic [AW-1:0]               top_idx;

    assign parent_idx = (hole_reg - AW'(1)) >> 1;
    assign child_a    = {hole_reg, 1'b1};
    assign child_b    = child_a + (AW+1)'(1);
    assign use_b      = (child_b < {1'b0, ext_last_reg}) && (rd_a_reg.key > rd_b_reg.key);
    assign pick_ent   = use_b ? rd_b_reg : rd_a_reg;
    assign pick_idx   = use_b ? child_b[AW-1:0] : child_a[AW-1:0];
    assign out_free   = !out_valid_reg || out_ready;
    assign top_idx    = AW'(count_reg - CW'(1));

    // Pick the key size at arrival
    always_comb
    begin
        unique case (sort_select_reg)
            hsort_pkg::SEL_REAL: sel_key = real_size;
            hsort_pkg::SEL_DISK: sel_key = disk_size;
            default:             sel_key = data_size;
        endcase
    end

    // ------------------------------------------------------------------
    // Heap memory
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= heap_mem[rd_addr_a];
        rd_b_reg <= heap_mem[rd_addr_b];
    end

    // ------------------------------------------------------------------
    // State and control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= hsort_pkg::ST_IDLE;
            sort_select_reg <= hsort_pkg::SEL_DATA;
            count_reg       <= '0;
            ovf_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                sort_select_reg <= cfg_wr_data;
            end
        end
    end

    // Payload and index registers
    always_ff @(posedge clk)
    begin
        new_reg         <= new_next;
        kept_reg        <= kept_next;
        last_reg        <= last_next;
        hole_reg        <= hole_next;
        ext_last_reg    <= ext_last_next;
        idx_reg         <= idx_next;
        mov_reg         <= mov_next;
        out_ent_reg     <= out_ent_next;
        valid_entry_reg <= valid_entry_next;
        ovf_out_reg     <= ovf_out_next;
        last_out_reg    <= last_out_next;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ovf_next         = ovf_reg;
        new_next         = new_reg;
        kept_next        = kept_reg;
        last_next        = last_reg;
        hole_next        = hole_reg;
        ext_last_next    = ext_last_reg;
        idx_next         = idx_reg;
        mov_next         = mov_reg;
        out_ent_next     = out_ent_reg;
        valid_entry_next = valid_entry_reg;
        ovf_out_next     = ovf_out_reg;
        last_out_next    = last_out_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        in_ready         = 1'b0;
        rd_addr_a        = idx_reg;
        rd_addr_b        = '0;
        wr_en            = 1'b0;
        wr_addr          = hole_reg;
        wr_data          = new_reg;

        unique case (state_reg)
            // Take one item and latch its key
            hsort_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    new_next.key = sel_key;
                    new_next.tag = entry_tag;
                    kept_next    = (data_size != '0);
                    last_next    = last_in;
                    state_next   = hsort_pkg::ST_INS;
                end
            end

            // Start insertion, or drop when zero-sized or full
            hsort_pkg::ST_INS:
            begin
                if (!kept_reg)
                begin
                    state_next = hsort_pkg::ST_DECIDE;
                end
                else if (count_reg < CW'(HEAP_DEPTH))
                begin
                    hole_next  = AW'(count_reg);
                    state_next = hsort_pkg::ST_UP_RD;
                end
                else
                begin
                    ovf_next   = 1'b1;
                    state_next = hsort_pkg::ST_DECIDE;
                end
            end

            // Sift up: fetch parent, or place at root
            hsort_pkg::ST_UP_RD:
            begin
                rd_addr_a = parent_idx;
                if (hole_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = hsort_pkg::ST_DECIDE;
                end
                else
                begin
                    state_next = hsort_pkg::ST_UP_CMP;
                end
            end

            // Sift up: move parent down or settle
            hsort_pkg::ST_UP_CMP:
            begin
                wr_en = 1'b1;
                if (rd_a_reg.key > new_reg.key)
                begin
                    wr_data    = rd_a_reg;
                    hole_next  = parent_idx;
                    state_next = hsort_pkg::ST_UP_RD;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = hsort_pkg::ST_DECIDE;
                end
            end

            // After the item: sort, send marker, or wait for more
            hsort_pkg::ST_DECIDE:
            begin
                if (!last_reg)
                begin
                    state_next = hsort_pkg::ST_IDLE;
                end
                else if (count_reg == '0)
                begin
                    state_next = hsort_pkg::ST_EMPTY;
                end
                else
                begin
                    ext_last_next = top_idx;
                    state_next    = hsort_pkg::ST_EX_RD;
                end
            end

            // Extraction: fetch the tail entry and the root
            hsort_pkg::ST_EX_RD:
            begin
                rd_addr_a  = ext_last_reg;
                rd_addr_b  = '0;
                state_next = hsort_pkg::ST_EX_MOVE;
            end

            // Extraction: park root at the tail, hold the tail entry
            hsort_pkg::ST_EX_MOVE:
            begin
                wr_en      = 1'b1;
                wr_addr    = ext_last_reg;
                wr_data    = rd_b_reg;
                mov_next   = rd_a_reg;
                hole_next  = '0;
                state_next = hsort_pkg::ST_SD_RD;
            end

            // Sift down: fetch both children, or settle at a leaf
            hsort_pkg::ST_SD_RD:
            begin
                rd_addr_a = child_a[AW-1:0];
                rd_addr_b = child_b[AW-1:0];
                if (child_a < {1'b0, ext_last_reg})
                begin
                    state_next = hsort_pkg::ST_SD_CMP;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_data    = mov_reg;
                    state_next = hsort_pkg::ST_EX_NEXT;
                end
            end

            // Sift down: lift the smaller child or settle
            hsort_pkg::ST_SD_CMP:
            begin
                wr_en = 1'b1;
                if (pick_ent.key < mov_reg.key)
                begin
                    wr_data    = pick_ent;
                    hole_next  = pick_idx;
                    state_next = hsort_pkg::ST_SD_RD;
                end
                else
                begin
                    wr_data    = mov_reg;
                    state_next = hsort_pkg::ST_EX_NEXT;
                end
            end

            // Advance to the next extraction step or start sending
            hsort_pkg::ST_EX_NEXT:
            begin
                if (ext_last_reg == '0)
                begin
                    idx_next   = '0;
                    state_next = hsort_pkg::ST_EMIT_RD;
                end
                else
                begin
                    ext_last_next = ext_last_reg - AW'(1);
                    state_next    = hsort_pkg::ST_EX_RD;
                end
            end

            // Emit: fetch the next sorted entry
            hsort_pkg::ST_EMIT_RD:
            begin
                rd_addr_a  = idx_reg;
                state_next = hsort_pkg::ST_EMIT_LD;
            end

            // Emit: load the output register when it frees up
            hsort_pkg::ST_EMIT_LD:
            begin
                rd_addr_a = idx_reg;
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_ent_next     = rd_a_reg;
                    valid_entry_next = 1'b1;
                    ovf_out_next     = ovf_reg;
                    last_out_next    = (idx_reg == top_idx);
                    if (idx_reg == top_idx)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = hsort_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = hsort_pkg::ST_EMIT_RD;
                    end
                end
            end

            // Send the empty-load marker
            hsort_pkg::ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_ent_next     = '0;
                    valid_entry_next = 1'b0;
                    ovf_out_next     = ovf_reg;
                    last_out_next    = 1'b1;
                    ovf_next         = 1'b0;
                    state_next       = hsort_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = hsort_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign out_valid   = out_valid_reg;
    assign out_tag     = out_ent_reg.tag;
    assign out_key     = out_ent_reg.key;
    assign valid_entry = valid_entry_reg;
    assign overflowed  = ovf_out_reg;
    assign last_out    = last_out_reg;

`ifndef SYNTH
    // Store fill never passes its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HEAP_DEPTH))
        else $error("entry count exceeds heap depth");

    // A dropped entry implies a full store until the run clears both
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == CW'(HEAP_DEPTH)))
        else $error("overflow flagged with free heap slots");

    // Sift-down hole stays inside the live heap region
    a_hole_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hsort_pkg::ST_SD_RD) |-> (hole_reg <= ext_last_reg))
        else $error("sift-down hole outside heap");
`endif

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the heap sorter of directory entries.
module testbench;

    localparam int unsigned KEY_W = hsort_pkg::KEY_W;
    localparam int unsigned TAG_W = hsort_pkg::TAG_W;
    localparam int unsigned SEL_W = hsort_pkg::SEL_W;
    localparam int unsigned VAL_W = KEY_W + 1;
    localparam int unsigned STORE_DEPTH = 64;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned CALM_ITEMS = 80;
    localparam logic [SEL_W-1:0] SEL_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] SIZE_MAX = {KEY_W{1'b1}};

    typedef enum int {LOAD_MIXED, LOAD_FULL, LOAD_EMPTY} load_kind_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
        logic             valid_entry;
        logic             overflowed;
        logic             last_out;
    } sorted_result_t;

    // Mirror of the sorter: heap contents, count, drop flag and key select.
    class size_sort_board;
        logic [KEY_W-1:0] heap_key [STORE_DEPTH];
        logic [TAG_W-1:0] heap_tag [STORE_DEPTH];
        int unsigned      stored = 0;
        bit               dropped = 1'b0;
        logic [SEL_W-1:0] key_select = hsort_pkg::SEL_DATA;
        sorted_result_t   pending [$];
        int unsigned      errors = 0;

        task report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
            errors++;
        endtask

        // Insert at the bottom and climb while the parent key is larger.
        function void sift_up(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
            int unsigned hole;
            int unsigned parent;
            hole = stored;
            while (hole > 0)
            begin
                parent = (hole - 1) / 2;
                if (heap_key[parent] > key)
                begin
                    heap_key[hole] = heap_key[parent];
                    heap_tag[hole] = heap_tag[parent];
                    hole = parent;
                end
                else
                    break;
            end
            heap_key[hole] = key;
            heap_tag[hole] = tag;
            stored++;
        endfunction

        // In-place heapsort on the min-heap: leaves keys in descending order.
        function void sort_descending();
            int               n;
            int               i;
            int               tail;
            int               hole;
            int               child;
            logic [KEY_W-1:0] mkey;
            logic [TAG_W-1:0] mtag;
            n = int'(stored);
            for (i = 1; i <= n; i++)
            begin
                tail = n - i;
                mkey = heap_key[tail];
                mtag = heap_tag[tail];
                hole = 0;
                heap_key[tail] = heap_key[0];
                heap_tag[tail] = heap_tag[0];
                tail--;
                while (hole * 2 + 1 <= tail)
                begin
                    child = hole * 2 + 1;
                    if (child < tail && heap_key[child] > heap_key[child + 1])
                        child++;
                    if (heap_key[child] < mkey)
                    begin
                        heap_key[hole] = heap_key[child];
                        heap_tag[hole] = heap_tag[child];
                        hole = child;
                    end
                    else
                        break;
                end
                heap_key[hole] = mkey;
                heap_tag[hole] = mtag;
            end
        endfunction

        // Account for one accepted entry; a last entry queues the sorted run.
        function void note_entry(logic [TAG_W-1:0] tag, logic [KEY_W-1:0] dsz,
                                 logic [KEY_W-1:0] rsz, logic [KEY_W-1:0] ksz, bit is_last);
            logic [KEY_W-1:0] key;
            int unsigned      k;
            if (dsz != 0)
            begin
                case (key_select)
                    hsort_pkg::SEL_REAL: key = rsz;
                    hsort_pkg::SEL_DISK: key = ksz;
                    default:             key = dsz;
                endcase
                if (stored < STORE_DEPTH)
                    sift_up(key, tag);
                else
                    dropped = 1'b1;
            end
            if (!is_last)
                return;
            if (stored == 0)
                pending.push_back({{TAG_W{1'b0}}, {KEY_W{1'b0}}, 1'b0, dropped, 1'b1});
            else
            begin
                sort_descending();
                for (k = 0; k < stored; k++)
                    pending.push_back({heap_tag[k], heap_key[k], 1'b1, dropped,
                                       k + 1 == stored});
            end
            stored = 0;
            dropped = 1'b0;
        endfunction

        // Compare one emitted result with the oldest expectation.
        task check_result(sorted_result_t got);
            sorted_result_t want;
            if (pending.size() == 0)
            begin
                report("result with nothing expected, tag", VAL_W'(got.tag), VAL_W'(0));
                return;
            end
            want = pending.pop_front();
            if (got.tag !== want.tag)
                report("out_tag", VAL_W'(got.tag), VAL_W'(want.tag));
            if (got.key !== want.key)
                report("out_key", VAL_W'(got.key), VAL_W'(want.key));
            if (got.valid_entry !== want.valid_entry)
                report("valid_entry", VAL_W'(got.valid_entry), VAL_W'(want.valid_entry));
            if (got.overflowed !== want.overflowed)
                report("overflowed", VAL_W'(got.overflowed), VAL_W'(want.overflowed));
            if (got.last_out !== want.last_out)
                report("last_out", VAL_W'(got.last_out), VAL_W'(want.last_out));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [SEL_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_ready;
    logic [TAG_W-1:0] entry_tag;
    logic [KEY_W-1:0] data_size;
    logic [KEY_W-1:0] real_size;
    logic [KEY_W-1:0] disk_size;
    logic             last_in;
    logic             out_valid;
    logic             out_ready;
    logic [TAG_W-1:0] out_tag;
    logic [KEY_W-1:0] out_key;
    logic             valid_entry;
    logic             overflowed;
    logic             last_out;

    size_sort_board board = new;
    int unsigned    in_idle_pct = 20;
    int unsigned    out_idle_pct = 20;
    int unsigned    items_sent = 0;
    bit             hold_req = 1'b0;

    heap_sort_entries_by_size #(
        .HEAP_DEPTH(STORE_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .entry_tag(entry_tag),
        .data_size(data_size),
        .real_size(real_size),
        .disk_size(disk_size),
        .last_in(last_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_tag(out_tag),
        .out_key(out_key),
        .valid_entry(valid_entry),
        .overflowed(overflowed),
        .last_out(last_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pick a size from a mix of tiny values (ties), extremes, powers of two, 20-bit values and full-width noise.
    function automatic logic [KEY_W-1:0] pick_size();
        logic [63:0] word;
        word = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return KEY_W'($urandom_range(0, 7));
            1: return SIZE_MAX;
            2: return KEY_W'(1) << $urandom_range(0, KEY_W - 1);
            3: return KEY_W'(word[19:0]);
            default: return word[KEY_W-1:0];
        endcase
    endfunction

    // Offer one entry, with an optional idle burst ahead of it; return on acceptance.
    task automatic send_entry(logic [TAG_W-1:0] tag, logic [KEY_W-1:0] dsz,
                              logic [KEY_W-1:0] rsz, logic [KEY_W-1:0] ksz, bit is_last);
        @(negedge clk);
        if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid <= 1'b1;
        entry_tag <= tag;
        data_size <= dsz;
        real_size <= rsz;
        disk_size <= ksz;
        last_in <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_entry(tag, dsz, rsz, ksz, is_last);
        items_sent++;
    endtask

    // Drop valid, wait for every expected result, then let the block finish.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_key_select(logic [SEL_W-1:0] sel);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= sel;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        board.key_select = sel;
    endtask

    // Send one load of random entries, the final one marked last.
    task automatic send_load(int unsigned count, load_kind_t kind);
        int unsigned      i;
        logic [KEY_W-1:0] dsz;
        for (i = 0; i < count; i++)
        begin
            dsz = pick_size();
            if (kind == LOAD_EMPTY || (kind == LOAD_MIXED && $urandom_range(0, 7) == 0))
                dsz = '0;
            else if (dsz == 0)
                dsz = KEY_W'(1);
            // change the key mid-load now and then; stored keys must not move
            if (kind == LOAD_MIXED && i != 0 && $urandom_range(0, 49) == 0)
            begin
                settle();
                write_key_select(SEL_W'($urandom_range(0, 3)));
            end
            send_entry(TAG_W'($urandom), dsz, pick_size(), pick_size(), i + 1 == count);
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Check every emitted result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result({out_tag, out_key, valid_entry, overflowed, last_out});
    end

    // End the run when no item moves on either side for too long.
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        int unsigned loads;
        int unsigned count;
        load_kind_t  kind;
        loads = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = hsort_pkg::SEL_DATA;
        in_valid = 1'b0;
        entry_tag = '0;
        data_size = '0;
        real_size = '0;
        disk_size = '0;
        last_in = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty load right after reset
        write_key_select(hsort_pkg::SEL_DATA);
        send_entry(16'h0000, '0, SIZE_MAX, SIZE_MAX, 1'b1);
        settle();

        // Data-size key: extremes, equal keys, a zero-size entry dropped
        send_entry(16'hFFFF, SIZE_MAX, '0, SIZE_MAX, 1'b0);
        send_entry(16'h0001, KEY_W'(1), SIZE_MAX, '0, 1'b0);
        send_entry(16'h0002, KEY_W'(5), KEY_W'(1), KEY_W'(1), 1'b0);
        send_entry(16'h0003, KEY_W'(5), KEY_W'(2), KEY_W'(2), 1'b0);
        send_entry(16'h0004, KEY_W'(5), KEY_W'(3), KEY_W'(3), 1'b0);
        send_entry(16'h0005, '0, SIZE_MAX, SIZE_MAX, 1'b0);
        send_entry(16'h0006, KEY_W'(3), KEY_W'(4), KEY_W'(4), 1'b1);
        settle();

        // Real-size key with zero keys, then disk key mid-load (keys latched)
        write_key_select(hsort_pkg::SEL_REAL);
        send_entry(16'h0010, KEY_W'(1), SIZE_MAX, KEY_W'(1), 1'b0);
        send_entry(16'h0011, KEY_W'(7), '0, KEY_W'(2), 1'b0);
        send_entry(16'h0012, KEY_W'(2), '0, KEY_W'(3), 1'b0);
        settle();
        write_key_select(hsort_pkg::SEL_DISK);
        send_entry(16'h0013, KEY_W'(9), KEY_W'(4), SIZE_MAX, 1'b0);
        send_entry(16'h0014, '0, KEY_W'(5), KEY_W'(5), 1'b1);
        settle();

        // Unused select falls back to the data size
        write_key_select(SEL_UNUSED);
        send_entry(16'h0020, SIZE_MAX, KEY_W'(1), KEY_W'(1), 1'b0);
        send_entry(16'h0021, KEY_W'(100), KEY_W'(2), KEY_W'(2), 1'b0);
        send_entry(16'h0022, KEY_W'({((KEY_W+1)/2){2'b01}}), KEY_W'(3), KEY_W'(3), 1'b1);
        settle();

        // Load made of zero-size entries only
        write_key_select(hsort_pkg::SEL_DATA);
        send_entry(16'hA5A5, '0, SIZE_MAX, SIZE_MAX, 1'b0);
        send_entry(16'h5A5A, '0, KEY_W'(1), KEY_W'(1), 1'b1);

        // Full store, then overflow, before the random mix
        send_load(STORE_DEPTH, LOAD_FULL);
        send_load(STORE_DEPTH + 6, LOAD_FULL);

        // Random loads, mostly small, with a calm stretch at the end
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent + CALM_ITEMS >= RANDOM_ITEMS)
            begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end
            else
            begin
                in_idle_pct = $urandom_range(0, 3) * 15;
                out_idle_pct = $urandom_range(0, 3) * 15;
            end
            // keep offering items straight after the long hold-off starts
            if (loads != 4 && $urandom_range(0, 3) == 0)
            begin
                settle();
                write_key_select(SEL_W'($urandom_range(0, 3)));
            end
            kind = LOAD_MIXED;
            case ($urandom_range(0, 19))
                0: count = $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 8);
                1, 2, 3: count = $urandom_range(13, 40);
                4:
                begin
                    count = $urandom_range(1, 3);
                    kind = LOAD_EMPTY;
                end
                default: count = $urandom_range(1, 12);
            endcase
            // one long receiver hold-off right after a mid-size load
            if (loads == 3)
            begin
                count = 24;
                send_load(count, LOAD_FULL);
                hold_req = 1'b1;
            end
            else
                send_load(count, kind);
            loads++;
        end

        settle();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
